@@ sv/bsst_pkg.sv @@
// Shared types, constants and status codes for the bounded set span tracker.
`default_nettype none

package bsst_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 7;
    localparam int STAT_W    = 2;
    localparam int OUT_RAW_W = STAT_W + CNT_W + 1 + 2 * VAL_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    typedef enum logic [STAT_W-1:0] {
        ST_ADDED = 2'd0,
        ST_FULL  = 2'd1,
        ST_DUP   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_UPDATE,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

@@ sv/bsst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bsst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/bounded_set_span_tracker.sv @@
// Top level of the bounded set span tracker: control, scan datapath and result register.
`default_nettype none

// Collects distinct signed 32-bit values, up to the smaller of the capacity
// register and DEPTH, and answers every request with one result: insert status
// (added, full, duplicate), the count after the request, and the shortest
// neighbour gap and the largest-minus-smallest span (both zero until two values
// are stored). A request that finds the store full goes from acceptance straight
// to the result state, and one into an empty store passes through the update
// state first; otherwise the stored entries are scanned through the single read
// port of the value memory, one entry per cycle, then drain and update follow.
// A result waits in the result state while the output register still holds the
// previous one. One request is processed at a time; the next one is accepted
// while the previous result still waits in the output register. Write capacity
// only while no request is in flight.
module bounded_set_span_tracker #(
    parameter int DEPTH = bsst_pkg::DEPTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // configuration
    input  wire logic                       cfg_wr_en,
    input  wire logic [bsst_pkg::CNT_W-1:0] cfg_wr_data,   // capacity
    // request channel
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [bsst_pkg::VAL_W-1:0] s_tdata,       // [31:0] value
    // result channel
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // [1:0] status, [8:2] count, [9] span_valid, [41:10] shortest_span,
    // [73:42] longest_span, [79:74] zero
    output logic      [bsst_pkg::OUT_W-1:0] m_tdata
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = bsst_pkg::CNT_W;
    localparam int VW      = bsst_pkg::VAL_W;
    localparam int LIM_MAX = (DEPTH < (2 ** CW) - 1) ? DEPTH : (2 ** CW) - 1;
    localparam int PAD_W   = bsst_pkg::OUT_W - bsst_pkg::OUT_RAW_W;

    bsst_pkg::state_t  state_reg, state_next;
    bsst_pkg::status_t status_reg, status_next;

    logic [CW-1:0]        capacity_reg, capacity_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic                 pend_reg, pend_next;
    logic signed [VW-1:0] value_reg, value_next;
    logic signed [VW-1:0] min_reg, min_next;
    logic signed [VW-1:0] max_reg, max_next;
    logic [VW-1:0]        gap_reg, gap_next;
    logic                 dup_reg, dup_next;
    logic                 hb_reg, hb_next;
    logic                 ha_reg, ha_next;
    logic signed [VW-1:0] below_reg, below_next;
    logic signed [VW-1:0] above_reg, above_next;
    logic                 m_valid_reg, m_valid_next;
    logic [bsst_pkg::OUT_W-1:0] m_data_reg, m_data_next;

    logic [CW-1:0]        limit;
    logic                 out_free;
    logic                 ram_we;
    logic                 ram_re;
    logic [VW-1:0]        ram_rdata;
    logic signed [VW-1:0] entry;
    logic [VW-1:0]        gap_lo;
    logic [VW-1:0]        gap_hi;
    logic [VW-1:0]        gap_tmp;
    logic                 span_valid;
    logic [VW-1:0]        shortest;
    logic [VW-1:0]        longest;

    assign limit    = (capacity_reg > CW'(LIM_MAX)) ? CW'(LIM_MAX) : capacity_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign entry    = $signed(ram_rdata);

    bsst_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(count_reg)),
        .wdata (value_reg),
        .re    (ram_re),
        .raddr (AW'(idx_reg)),
        .rdata (ram_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bsst_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    priority if (count_reg >= limit) state_next = bsst_pkg::S_DONE;
                    else if (count_reg == '0)        state_next = bsst_pkg::S_UPDATE;
                    else                             state_next = bsst_pkg::S_SCAN;
                end
            end
            bsst_pkg::S_SCAN: begin
                if (idx_reg == count_reg - CW'(1)) state_next = bsst_pkg::S_DRAIN;
            end
            bsst_pkg::S_DRAIN:  state_next = bsst_pkg::S_UPDATE;
            bsst_pkg::S_UPDATE: state_next = bsst_pkg::S_DONE;
            bsst_pkg::S_DONE: begin
                if (out_free) state_next = bsst_pkg::S_IDLE;
            end
            default: state_next = bsst_pkg::S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        s_tready = 1'b0;
        ram_re   = 1'b0;
        ram_we   = 1'b0;
        unique case (state_reg)
            bsst_pkg::S_IDLE:   s_tready = 1'b1;
            bsst_pkg::S_SCAN:   ram_re   = 1'b1;
            bsst_pkg::S_UPDATE: ram_we   = !dup_reg;
            default: ;
        endcase
    end

    // result fields from the current state registers
    always_comb begin
        span_valid = count_reg >= CW'(2);
        shortest   = span_valid ? gap_reg : '0;
        longest    = span_valid ? VW'(max_reg - min_reg) : '0;
    end

    // datapath
    always_comb begin
        capacity_next = cfg_wr_en ? cfg_wr_data : capacity_reg;
        status_next   = status_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pend_next     = ram_re;
        value_next    = value_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        gap_next      = gap_reg;
        dup_next      = dup_reg;
        hb_next       = hb_reg;
        ha_next       = ha_reg;
        below_next    = below_reg;
        above_next    = above_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        gap_lo        = VW'(value_reg - below_reg);
        gap_hi        = VW'(above_reg - value_reg);
        gap_tmp       = gap_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (state_reg == bsst_pkg::S_IDLE && s_tvalid) begin
            value_next  = $signed(s_tdata);
            idx_next    = '0;
            dup_next    = 1'b0;
            hb_next     = 1'b0;
            ha_next     = 1'b0;
            status_next = bsst_pkg::ST_FULL;
        end

        if (state_reg == bsst_pkg::S_SCAN) begin
            idx_next = idx_reg + CW'(1);
        end

        // compare the entry read in the previous cycle
        if (pend_reg) begin
            priority if (entry == value_reg) begin
                dup_next = 1'b1;
            end else if (entry < value_reg) begin
                if (!hb_reg || entry > below_reg) begin
                    below_next = entry;
                    hb_next    = 1'b1;
                end
            end else begin
                if (!ha_reg || entry < above_reg) begin
                    above_next = entry;
                    ha_next    = 1'b1;
                end
            end
        end

        if (state_reg == bsst_pkg::S_UPDATE) begin
            if (dup_reg) begin
                status_next = bsst_pkg::ST_DUP;
            end else begin
                status_next = bsst_pkg::ST_ADDED;
                count_next  = count_reg + CW'(1);
                if (count_reg == '0) begin
                    min_next = value_reg;
                    max_next = value_reg;
                end else begin
                    if (value_reg < min_reg) min_next = value_reg;
                    if (value_reg > max_reg) max_next = value_reg;
                end
                if (hb_reg && gap_lo < gap_tmp) gap_tmp = gap_lo;
                if (ha_reg && gap_hi < gap_tmp) gap_tmp = gap_hi;
                gap_next = gap_tmp;
            end
        end

        if (state_reg == bsst_pkg::S_DONE && out_free) begin
            m_valid_next = 1'b1;
            m_data_next  = {{PAD_W{1'b0}}, longest, shortest, span_valid, count_reg,
                            status_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bsst_pkg::S_IDLE;
            capacity_reg <= '0;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            min_reg      <= '0;
            max_reg      <= '0;
            gap_reg      <= '1;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            capacity_reg <= capacity_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            gap_reg      <= gap_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        idx_reg    <= idx_next;
        value_reg  <= value_next;
        dup_reg    <= dup_next;
        hb_reg     <= hb_next;
        ha_reg     <= ha_next;
        below_reg  <= below_next;
        above_reg  <= above_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire
